@@ hw/rtl/smf_pkg.sv @@
// Shared types and constants for the sliding window median filter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package smf_pkg;

   // Default sizing of the window and of one sample
   localparam int MAX_WINDOW_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   // Window length register
   localparam int          CFG_W               = 5;
   localparam logic [4:0]  WINDOW_LENGTH_RESET = 5'd5;

   // Transaction kinds on the request channel
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // Per-cycle command broadcast to every cell of the sorted chain
   typedef struct packed {
      logic step;   // insert a new sample (and evict the oldest when full)
      logic clear;  // empty the chain
      logic full;   // chain holds the whole window before this step
   } smf_ctl_type;

endpackage

@@ hw/rtl/smf_ifs.sv @@
// Valid/ready channel interfaces of the median filter: request and response.
// Depends on smf_pkg for default widths.
`timescale 1ns / 1ps

interface smf_req_if import smf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, kind, sample, input ready);
   modport sink   (input valid, kind, sample, output ready);
endinterface

interface smf_rsp_if import smf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] median;
   logic                          window_full;

   modport source (output valid, median, window_full, input ready);
   modport sink   (input valid, median, window_full, output ready);
endinterface

@@ hw/rtl/smf_cell.sv @@
// One cell of the sorted chain: holds a sample, its age and a valid bit.
// Depends on smf_pkg (smf_ctl_type); instantiated in a row by the top level.
`timescale 1ns / 1ps

module smf_cell import smf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int AGE_W       = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smf_ctl_type                   ctl,
   input  logic signed [SAMPLE_BITS-1:0] new_sample,
   input  logic [AGE_W-1:0]              evict_age,
   // post-eviction view of the left neighbor
   input  logic                          left_lt,
   input  logic signed [SAMPLE_BITS-1:0] left_d_val,
   input  logic                          left_d_valid,
   input  logic [AGE_W-1:0]              left_d_age,
   // stored contents of the right neighbor
   input  logic signed [SAMPLE_BITS-1:0] right_val,
   input  logic                          right_valid,
   input  logic [AGE_W-1:0]              right_age,
   input  logic                          del_in,
   output logic signed [SAMPLE_BITS-1:0] val_q,
   output logic                          valid_q,
   output logic [AGE_W-1:0]              age_q,
   output logic signed [SAMPLE_BITS-1:0] d_val,
   output logic                          d_valid,
   output logic [AGE_W-1:0]              d_age,
   output logic                          lt_out,
   output logic                          del_out
);

   logic signed [SAMPLE_BITS-1:0] val_ff, val_in;
   logic                          valid_ff, valid_in;
   logic [AGE_W-1:0]              age_ff, age_in;
   logic                          evict_here;

   // The oldest sample leaves once the window is full
   assign evict_here = ctl.full && valid_ff && (age_ff == evict_age);
   assign del_out    = del_in || evict_here;

   // Chain with the oldest removed: cells at or past the hole pull from the right
   always_comb begin
      if (del_out) begin
         d_val   = right_val;
         d_valid = right_valid;
         d_age   = right_age;
      end else begin
         d_val   = val_ff;
         d_valid = valid_ff;
         d_age   = age_ff;
      end
   end

   // Empty cells count as larger than any sample
   assign lt_out = !d_valid || (new_sample < d_val);

   // Insert: shift right past the insertion point, new sample at it
   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      age_in   = age_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.step) begin
         if (left_lt) begin
            val_in   = left_d_val;
            valid_in = left_d_valid;
            age_in   = left_d_age + AGE_W'(1);
         end else if (lt_out) begin
            val_in   = new_sample;
            valid_in = 1'b1;
            age_in   = '0;
         end else begin
            val_in   = d_val;
            valid_in = d_valid;
            age_in   = d_age + AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      age_ff <= age_in;
   end

   assign val_q   = val_ff;
   assign valid_q = valid_ff;
   assign age_q   = age_ff;

endmodule

@@ hw/rtl/smf_median.sv @@
// Median pick from the sorted chain: middle cell, or truncated mean of the two middle cells.
// Depends on smf_pkg for default widths.
`timescale 1ns / 1ps

module smf_median import smf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int AGE_W       = 4,
   parameter int LEN_W       = 5
) (
   input  logic signed [SAMPLE_BITS-1:0] sorted_val [MAX_WINDOW],
   input  logic [LEN_W-1:0]              held_count,
   output logic signed [SAMPLE_BITS-1:0] median
);

   logic [AGE_W-1:0]              idx_hi;
   logic [AGE_W-1:0]              idx_lo;
   logic signed [SAMPLE_BITS-1:0] val_hi;
   logic signed [SAMPLE_BITS-1:0] val_lo;
   logic signed [SAMPLE_BITS:0]   pair_sum;
   logic signed [SAMPLE_BITS:0]   pair_adj;

   // Middle positions of the held samples
   assign idx_hi = AGE_W'(held_count >> 1);
   assign idx_lo = idx_hi - AGE_W'(1);
   assign val_hi = sorted_val[idx_hi];
   assign val_lo = sorted_val[idx_lo];

   // Halve toward zero: bias negative sums by one before the arithmetic shift
   assign pair_sum = {val_lo[SAMPLE_BITS-1], val_lo} + {val_hi[SAMPLE_BITS-1], val_hi};
   assign pair_adj = pair_sum + {{SAMPLE_BITS{1'b0}}, pair_sum[SAMPLE_BITS]};

   assign median = held_count[0] ? val_hi : pair_adj[SAMPLE_BITS:1];

endmodule

@@ hw/rtl/sliding_window_median_filter_unit.sv @@
// Sliding window median filter, top level: sorted cell chain, length register, output stage.
// A sample transaction updates the chain and sets the pending flag; its median then moves into the output register.
// Throughput: one transaction per cycle; each cell does one evict-and-insert step per cycle,
// and the chain holds while its pending result cannot move into a still-occupied output register.
// Reset (synchronous): window empty, window length 5, no response pending.
// Depends on smf_pkg, smf_ifs, smf_cell and smf_median.
`timescale 1ns / 1ps

module sliding_window_median_filter_unit import smf_pkg::*; #(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   smf_req_if.sink          req_if,
   smf_rsp_if.source        rsp_if,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WINDOW);

   logic [CFG_W-1:0]              window_length_ff;
   logic [LEN_W-1:0]              count_ff, count_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] median_ff;
   logic                          full_ff;
   logic [LEN_W-1:0]              len_eff;
   logic                          out_free;
   logic                          req_fire;
   logic                          s1_move;
   smf_ctl_type                   ctl;
   logic signed [SAMPLE_BITS-1:0] median_pick;

   logic signed [SAMPLE_BITS-1:0] c_val   [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]         c_valid;
   logic [AGE_W-1:0]              c_age   [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] d_val   [MAX_WINDOW];
   logic                          d_valid [MAX_WINDOW];
   logic [AGE_W-1:0]              d_age   [MAX_WINDOW];
   logic                          lt      [MAX_WINDOW];
   logic                          del     [MAX_WINDOW];

   // Window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
      end else if (csr_wr_en) begin
         window_length_ff <= csr_wr_data;
      end
   end

   // Effective length: zero acts as one, oversize clamps to the chain length
   always_comb begin
      if (window_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (int'(window_length_ff) > MAX_WINDOW) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = LEN_W'(window_length_ff);
      end
   end

   // Handshake: chain moves when its last result can go to the output register
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = !s1_valid_ff || out_free;
   assign req_fire      = req_if.valid && req_if.ready;
   assign s1_move       = s1_valid_ff && out_free;

   assign ctl.step  = req_fire && (req_if.kind == KIND_SAMPLE);
   assign ctl.clear = (req_fire && (req_if.kind == KIND_CLEAR)) || csr_wr_en;
   assign ctl.full  = (count_ff == len_eff);

   // Fill count
   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.step && (count_ff < len_eff)) begin
         count_in = count_ff + LEN_W'(1);
      end
   end

   // Cell chain
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic                          left_lt;
      logic signed [SAMPLE_BITS-1:0] left_d_val;
      logic                          left_d_valid;
      logic [AGE_W-1:0]              left_d_age;
      logic                          del_in;
      logic signed [SAMPLE_BITS-1:0] right_val;
      logic                          right_valid;
      logic [AGE_W-1:0]              right_age;

      if (i == 0) begin : g_head
         assign left_lt      = 1'b0;
         assign left_d_val   = '0;
         assign left_d_valid = 1'b0;
         assign left_d_age   = '0;
         assign del_in       = 1'b0;
      end else begin : g_mid
         assign left_lt      = lt[i-1];
         assign left_d_val   = d_val[i-1];
         assign left_d_valid = d_valid[i-1];
         assign left_d_age   = d_age[i-1];
         assign del_in       = del[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_tail
         assign right_val   = '0;
         assign right_valid = 1'b0;
         assign right_age   = '0;
      end else begin : g_body
         assign right_val   = c_val[i+1];
         assign right_valid = c_valid[i+1];
         assign right_age   = c_age[i+1];
      end

      smf_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_W       (AGE_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .new_sample   (req_if.sample),
         .evict_age    (AGE_W'(len_eff - LEN_W'(1))),
         .left_lt      (left_lt),
         .left_d_val   (left_d_val),
         .left_d_valid (left_d_valid),
         .left_d_age   (left_d_age),
         .right_val    (right_val),
         .right_valid  (right_valid),
         .right_age    (right_age),
         .del_in       (del_in),
         .val_q        (c_val[i]),
         .valid_q      (c_valid[i]),
         .age_q        (c_age[i]),
         .d_val        (d_val[i]),
         .d_valid      (d_valid[i]),
         .d_age        (d_age[i]),
         .lt_out       (lt[i]),
         .del_out      (del[i])
      );
   end

   // Median of the chain as it stands after the last step
   smf_median #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_WINDOW  (MAX_WINDOW),
      .AGE_W       (AGE_W),
      .LEN_W       (LEN_W)
   ) u_median (
      .sorted_val (c_val),
      .held_count (count_ff),
      .median     (median_pick)
   );

   // Pending-result flag and output register
   always_comb begin
      s1_valid_in  = ctl.step || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         median_ff <= median_pick;
         full_ff   <= (count_ff == len_eff);
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.median      = median_ff;
   assign rsp_if.window_full = full_ff;

   // Occupied cells are exactly the fill count
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(c_valid) == int'(count_ff))
      else $error("cell valid bits disagree with fill count");

   // Fill count never passes the effective length
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= len_eff)
      else $error("fill count exceeds window length");

   // A stalled result keeps the chain frozen
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("input taken while a result is stuck");

   // An accepted sample leaves a pending result behind
   a_sample_pends: assert property (@(posedge clock) disable iff (reset)
      ctl.step |=> s1_valid_ff)
      else $error("accepted sample produced no pending result");

   // A length write empties the window
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (count_ff == '0) && (c_valid == '0))
      else $error("window not emptied by length write");

endmodule
